// File: rtl/core/flp_pkg.sv
// Shared types and constants for the log1p approximation pipeline.
package flp_pkg;

  localparam logic [31:0] ONE_BITS   = 32'h3F80_0000;
  localparam logic [31:0] INF_BITS   = 32'h7F80_0000;
  // Fractional part of 2*ln2 in Q32; the integer part (1.0) is added separately.
  localparam logic [30:0] SCALE_FRAC = 31'd1659121648;
  localparam logic [61:0] ROUND_HALF = 62'h0000_0000_8000_0000;
  localparam logic [30:0] LOG_MAX    = 31'd1488522236;

  typedef struct packed {
    logic [31:0] sample_bits;
    logic        last_in;
  } flp_in_t;

  typedef struct packed {
    logic [30:0] log_value;
    logic        last_out;
  } flp_out_t;

  // Offset of the rounded 1+x bit pattern from 1.0, with its last flag.
  typedef struct packed {
    logic [30:0] diff;
    logic        last;
  } flp_diff_t;

endpackage

// File: rtl/core/fast_log1p_approx.sv
// Top level: piecewise-linear ln(1+x) of an IEEE single-precision word, Q7.24 result.
// Pipeline: stages 1-2 in flp_add_one, stages 3-4 here, each with a registered valid bit.
// Throughput: one word per cycle; busy is always low, four words in flight at most.
// Reset: synchronous active-low rst_n clears every valid bit; data registers are not reset.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module fast_log1p_approx (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  flp_pkg::flp_in_t  in_word,
  output logic              out_valid,
  output flp_pkg::flp_out_t out_word
);
  import flp_pkg::*;

  logic      d_valid;
  flp_diff_t d_word;

  // Stages 1-2: clamp, add 1.0 with round-to-nearest-even, subtract 1.0 bits.
  // Result is d = u - 0x3F800000 in 0..2^30, roughly log2(1+x) * 2^23.
  flp_add_one u_add_one (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .in_word  (in_word),
    .d_valid  (d_valid),
    .d_word   (d_word)
  );

  // Stage 3: d times the fractional part of 2*ln2 (31x31 multiply).
  // 2*ln2 in Q32 = 2^32 + SCALE_FRAC, so d*scale>>32 = d + (d*SCALE_FRAC)>>32.
  logic        v3_r;
  logic [61:0] prod_r, prod_nxt;
  logic [30:0] d3_r;
  logic        last3_r;

  assign prod_nxt = 62'(d_word.diff) * 62'(SCALE_FRAC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    d3_r    <= d_word.diff;
    last3_r <= d_word.last;
  end

  // Stage 4: round half up and add the integer part of the scale.
  logic        v4_r;
  flp_out_t    out_r, out_nxt;
  logic [61:0] rounded;

  always_comb begin
    rounded           = prod_r + ROUND_HALF;
    out_nxt.log_value = d3_r + {1'b0, rounded[61:32]};
    out_nxt.last_out  = last3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // Fully pipelined, nothing ever holds the input off.
  assign busy      = 1'b0;
  assign out_valid = v4_r;
  assign out_word  = out_r;

endmodule

// File: rtl/core/flp_add_one.sv
// Two-stage single-precision 1.0 + x adder (RNE) returning the bit offset from 1.0.
module flp_add_one (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  flp_pkg::flp_in_t  in_word,
  output logic              d_valid,
  output flp_pkg::flp_diff_t d_word
);
  import flp_pkg::*;

  // stage 1: classify and align
  logic        v1_r, v1_nxt;
  logic        last1_r;
  logic        force_one_r, force_one_nxt;
  logic        is_inf_r, is_inf_nxt;
  logic        case_a_r, case_a_nxt;
  logic [7:0]  ex_r, ex_nxt;
  logic [23:0] m_r, m_nxt;
  logic [25:0] inc_r, inc_nxt;
  logic [22:0] q_r, q_nxt;
  logic        g_r, g_nxt;
  logic        s_r, s_nxt;

  logic [31:0] xb;
  logic [7:0]  ex_eff;
  logic [7:0]  diff_a;
  logic [7:0]  diff_b;
  logic [4:0]  sh_a;
  logic [4:0]  dsh_b;
  logic [49:0] ext;

  assign xb     = in_word.sample_bits;
  assign ex_eff = (xb[30:23] == 8'd0) ? 8'd1 : xb[30:23];
  assign diff_a = xb[30:23] - 8'd127;
  assign diff_b = 8'd127 - ex_eff;
  assign sh_a   = 5'(8'd24 - diff_a);
  assign dsh_b  = (diff_b > 8'd26) ? 5'd26 : diff_b[4:0];
  assign ext    = {m_nxt, 26'd0} >> dsh_b;

  always_comb begin
    v1_nxt        = in_valid;
    force_one_nxt = (xb == 32'd0) || (xb > INF_BITS);
    is_inf_nxt    = (xb == INF_BITS);
    case_a_nxt    = (xb[30:23] >= 8'd127);
    ex_nxt        = xb[30:23];
    m_nxt         = {(xb[30:23] != 8'd0), xb[22:0]};
    // x >= 1: one ulp-scaled increment with a guard bit; at diff 24 it is the tie bit
    inc_nxt       = (diff_a <= 8'd24) ? (26'd1 << sh_a) : 26'd0;
    // x < 1: x shifted to the ulp of 1.0, plus guard and sticky
    q_nxt         = ext[48:26];
    g_nxt         = ext[25];
    s_nxt         = |ext[24:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last1_r     <= in_word.last_in;
    force_one_r <= force_one_nxt;
    is_inf_r    <= is_inf_nxt;
    case_a_r    <= case_a_nxt;
    ex_r        <= ex_nxt;
    m_r         <= m_nxt;
    inc_r       <= inc_nxt;
    q_r         <= q_nxt;
    g_r         <= g_nxt;
    s_r         <= s_nxt;
  end

  // stage 2: add, normalize, round, offset from 1.0
  logic        v2_r;
  flp_diff_t   d2_r, d2_nxt;
  logic [25:0] t;
  logic [23:0] keep;
  logic        g_a, s_a, rnd_a, rnd_b;
  logic [8:0]  e9;
  logic [31:0] ua, ub, u;

  always_comb begin
    t = {1'b0, m_r, 1'b0} + inc_r;
    if (t[25]) begin
      keep = t[25:2];
      g_a  = t[1];
      s_a  = t[0];
      e9   = {1'b0, ex_r} + 9'd1;
    end else begin
      keep = t[24:1];
      g_a  = t[0];
      s_a  = 1'b0;
      e9   = {1'b0, ex_r};
    end
    rnd_a = g_a & (s_a | keep[0]);
    // mantissa carry out of rounding bumps the exponent for free
    ua = {e9, keep[22:0]} + {31'd0, rnd_a};
    if (ua[31:23] >= 9'd255) begin
      ua = INF_BITS;
    end
    rnd_b = g_r & (s_r | q_r[0]);
    ub    = ONE_BITS + {9'd0, q_r} + {31'd0, rnd_b};
    if (force_one_r) begin
      u = ONE_BITS;
    end else if (is_inf_r) begin
      u = INF_BITS;
    end else if (case_a_r) begin
      u = ua;
    end else begin
      u = ub;
    end
    d2_nxt.diff = 31'(u - ONE_BITS);
    d2_nxt.last = last1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    d2_r <= d2_nxt;
  end

  assign d_valid = v2_r;
  assign d_word  = d2_r;

endmodule

// File: rtl/core/flp_checker.sv
// Port-level checks for fast_log1p_approx, bound to the top level.
module flp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input flp_pkg::flp_in_t  in_word,
  input logic              out_valid,
  input flp_pkg::flp_out_t out_word
);
  import flp_pkg::*;

  // Every accepted word comes out once, in order, and nothing else does.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4))
    |-> (out_valid == $past(start && !busy, 4)))
    else $error("flp: result strobe does not match accepted word");

  // Last flag travels with its word.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4))
    |-> (out_word.last_out == $past(in_word.last_in, 4)))
    else $error("flp: last flag mismatch");

  // Zero, negative and NaN inputs clamp to zero.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4)
     && $past((in_word.sample_bits == 32'd0) || (in_word.sample_bits > INF_BITS), 4))
    |-> (out_word.log_value == 31'd0))
    else $error("flp: clamped input gave nonzero result");

  // Result never exceeds the value for +inf.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.log_value <= LOG_MAX))
    else $error("flp: result out of range");

endmodule

bind fast_log1p_approx flp_checker u_flp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);

// File: test/fast_log1p_approx_tb.sv
// Self-checking testbench for fast_log1p_approx: random and corner-case words vs. a built-in predictor.
`timescale 1ns / 1ps

module fast_log1p_approx_tb;

  // Items in the random part; the directed corners come on top.
  localparam int unsigned RANDOM_WORDS = 2000;
  // Tail with no idling at all; the source always has a word ready.
  localparam int unsigned STEADY_TAIL  = 300;
  // Pipeline depth from the header of the top level, plus some margin.
  localparam int unsigned DRAIN_CYCLES = 12;
  // round(2*ln2 * 2^32): turns the bit offset from 1.0 into Q7.24 with 32 extra bits.
  localparam logic [63:0] TWO_LN2_Q32  = 64'd5954088944;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  flp_pkg::flp_in_t  in_word = '0;
  logic              out_valid;
  flp_pkg::flp_out_t out_word;

  flp_pkg::flp_in_t  word_src_q[$];   // words waiting to be presented
  flp_pkg::flp_out_t log_expect_q[$]; // predicted results, oldest first

  int unsigned mismatch_cnt = 0;
  int unsigned words_sent   = 0;
  int unsigned idle_left    = 0;
  logic        word_taken   = 1'b0; // start && !busy seen at the last rising edge

  fast_log1p_approx u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Bits of 1.0 + x in single precision, round to nearest even, for x > 0
  // (infinity and denormals included, NaN excluded by the caller).
  function automatic logic [31:0] one_plus_sample(input logic [31:0] xb);
    logic [7:0]  ex;
    logic [23:0] mx;
    logic [23:0] big_m;
    logic [23:0] tiny_m;
    int unsigned big_e;
    int unsigned tiny_e;
    int unsigned gap;
    int unsigned msb;
    int unsigned sh;
    int unsigned e;
    logic [63:0] s;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    ex = xb[30:23];
    mx = {1'b0, xb[22:0]};
    if (ex == 8'hFF) begin
      return flp_pkg::INF_BITS;
    end
    // Denormals share exponent 1 with no hidden bit.
    if (ex == 8'd0) begin
      ex = 8'd1;
    end else begin
      mx[23] = 1'b1;
    end
    if (ex >= 8'd127) begin
      big_e  = 32'(ex);
      big_m  = mx;
      tiny_e = 127;
      tiny_m = 24'h80_0000;
    end else begin
      big_e  = 127;
      big_m  = 24'h80_0000;
      tiny_e = 32'(ex);
      tiny_m = mx;
    end
    gap = big_e - tiny_e;
    // Smaller operand below half an ulp of the larger: sum is the larger.
    if (gap > 38) begin
      return {1'b0, big_e[7:0], big_m[22:0]};
    end
    // Exact sum in units of 2^(tiny_e-150).
    s = (64'(big_m) << gap) + 64'(tiny_m);
    msb = 0;
    for (int i = 0; i < 64; i++) begin
      if (s[i]) msb = i;
    end
    sh   = msb - 23;
    e    = tiny_e + sh;
    keep = s >> sh;
    if (sh > 0) begin
      rem  = s & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
      // Rounding carried into a new binade.
      if (keep[24]) begin
        keep = keep >> 1;
        e    = e + 1;
      end
    end
    if (e >= 255) begin
      return flp_pkg::INF_BITS;
    end
    return {1'b0, e[7:0], keep[22:0]};
  endfunction

  // Expected result word for one input word.
  function automatic flp_pkg::flp_out_t predict_log1p(input flp_pkg::flp_in_t w);
    flp_pkg::flp_out_t res;
    logic [31:0]       u;
    logic [63:0]       d;
    logic [63:0]       r;
    // Zero, anything with the sign bit, and NaN all clamp to +0.0, i.e. 1+x = 1.0.
    if (w.sample_bits == 32'd0 || w.sample_bits > flp_pkg::INF_BITS) begin
      u = flp_pkg::ONE_BITS;
    end else begin
      u = one_plus_sample(w.sample_bits);
    end
    d = 64'(u - flp_pkg::ONE_BITS);
    r = (d * TWO_LN2_Q32 + 64'h8000_0000) >> 32;  // round half up
    res.log_value = r[30:0];
    res.last_out  = w.last_in;
    return res;
  endfunction

  // One line per mismatch, and a count.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt++;
    $display("tb: %0t mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Random sample, weighted toward the regions where the rounding gets interesting.
  function automatic logic [31:0] random_sample();
    logic [22:0] frac;
    frac = 23'($urandom);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;                                                // any pattern
      2, 3: return {1'b0, 8'($urandom_range(100, 160)), frac};              // mid range
      4:    return {1'b0, 8'd0, frac};                                      // denormals
      5:    return {1'b0, 8'($urandom_range(160, 254)), frac};              // large
      6:    return {1'b0, 8'hFF, frac};                                     // inf / NaN
      7:    return {1'b0, 8'($urandom_range(101, 106)), frac};              // near half ulp
      8:    return {1'b0, 8'($urandom_range(148, 153)), frac};              // near 2^24
      default: return {1'b1, 31'($urandom)};                                // negatives
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents words at the falling edge, idles in random bursts.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !word_taken) begin
      // word still waiting for acceptance: hold it
    end else if (idle_left > 0) begin
      idle_left = idle_left - 1;
      start <= 1'b0;
    end else if (word_src_q.size() == 0) begin
      start <= 1'b0;
    end else if (word_src_q.size() > STEADY_TAIL && ((words_sent / 128) % 2 == 0)
                 && $urandom_range(0, 5) == 0) begin
      // start an idle burst that includes this one; every other block of
      // 128 words runs back to back
      idle_left = $urandom_range(0, 9);
      start <= 1'b0;
    end else begin
      start   <= 1'b1;
      in_word <= word_src_q.pop_front();
      words_sent++;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples at the rising edge, checks results and books accepted words.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    flp_pkg::flp_out_t want;
    word_taken = rst_n && start && !busy;
    if (rst_n) begin
      // Results are strobed for one cycle; each must match the oldest prediction.
      if (out_valid) begin
        if (log_expect_q.size() == 0) begin
          report_mismatch("unexpected result word", {1'b0, out_word.log_value}, 32'd0);
        end else begin
          want = log_expect_q.pop_front();
          if (out_word.log_value !== want.log_value)
            report_mismatch("log_value", {1'b0, out_word.log_value}, {1'b0, want.log_value});
          if (out_word.last_out !== want.last_out)
            report_mismatch("last_out", {31'd0, out_word.last_out}, {31'd0, want.last_out});
        end
      end
      if (word_taken) log_expect_q.push_back(predict_log1p(in_word));
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, fill the source queue, wait for the drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0]      corners[$];
    flp_pkg::flp_in_t w;
    corners = '{
      32'h0000_0000,  // +0.0
      32'h8000_0000,  // -0.0
      32'h7F80_0000,  // +inf: top of the output range
      32'hFF80_0000,  // -inf
      32'h7FC0_0000,  // quiet NaN
      32'h7F80_0001,  // signaling NaN
      32'hFFFF_FFFF,  // negative NaN, all ones
      32'h7FFF_FFFF,  // NaN, all mantissa bits
      32'h0000_0001,  // smallest denormal
      32'h007F_FFFF,  // largest denormal
      32'h3380_0000,  // 2^-24: exact tie, rounds to even (1.0)
      32'h3380_0001,  // just above the tie, rounds up
      32'h3400_0000,  // 2^-23: one ulp of 1.0
      32'h3F80_0000,  // 1.0
      32'h3F7F_FFFF,  // just below 1.0
      32'h4B7F_FFFF,  // 2^24-1: sum carries into a new binade
      32'h4B80_0000,  // 2^24: +1 is a tie, stays even
      32'h4B80_0001,  // 2^24+2: +1 is a tie, rounds up
      32'h5000_0000,  // far past half an ulp
      32'h7F7F_FFFF,  // largest finite
      32'hBF80_0000,  // -1.0
      32'h0080_0000   // smallest normal
    };
    foreach (corners[i]) begin
      w.sample_bits = corners[i];
      w.last_in     = i[0];
      word_src_q.push_back(w);
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      w.sample_bits = random_sample();
      w.last_in     = 1'($urandom);
      word_src_q.push_back(w);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every word handed over and the last one accepted.
    while (word_src_q.size() != 0 || start) @(posedge clk);
    while (log_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #500000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
rtl/core/flp_pkg.sv
rtl/core/flp_add_one.sv
rtl/core/fast_log1p_approx.sv
rtl/core/flp_checker.sv
test/fast_log1p_approx_tb.sv
